@@ sv/k_queues_shared_buffer_defines.svh @@
// assertion macros for the shared-store queue block
// used by the top level only; no other dependencies
`ifndef K_QUEUES_SHARED_BUFFER_DEFINES_SVH
`define K_QUEUES_SHARED_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define KQSB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kqsb assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define KQSB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kqsb assertion failed");
`else
`define KQSB_ASSERT_IMP(lbl, ante, cons)
`define KQSB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/kqsb_pkg.sv @@
// shared types and constants for the shared-store queue block
// no dependencies
package kqsb_pkg;

	localparam int DEF_SLOTS      = 16;
	localparam int DEF_NUM_QUEUES = 4;
	localparam int DATA_W         = 32;
	localparam int QNUM_W         = 2;
	localparam int ACT_W          = 3;
	localparam logic [ACT_W-1:0] ACT_RESET = 3'd4;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_EMPTY   = 2'd3
	} kqsb_status_t;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} kqsb_req_type_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} kqsb_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} kqsb_cmd_t;

endpackage

@@ sv/kqsb_if.sv @@
// request and response channel interfaces for the shared-store queue block
// depends on kqsb_pkg
interface kqsb_req_if;
	import kqsb_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [QNUM_W-1:0]        queue_num;
	logic signed [DATA_W-1:0] data_in;
	modport source (output valid, req_type, queue_num, data_in, input ready);
	modport sink (input valid, req_type, queue_num, data_in, output ready);
endinterface

interface kqsb_rsp_if;
	import kqsb_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] data_out;
	modport source (output valid, status, data_out, input ready);
	modport sink (input valid, status, data_out, output ready);
endinterface

@@ sv/kqsb_ctrl.sv @@
// controller: two-state sequencer and response valid flag
// depends on kqsb_pkg
module kqsb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output kqsb_pkg::kqsb_cmd_t cmd
);
	import kqsb_pkg::*;

	kqsb_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	// state and response flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// hold while the previous word still waits
				cmd.commit = !out_valid_q || rsp_ready;
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		out_valid_d = cmd.commit || (out_valid_q && !rsp_ready);
	end

	assign rsp_valid = out_valid_q;

endmodule

@@ sv/kqsb_dp.sv @@
// datapath: link and data memories, queue and free-list pointers, result register
// depends on kqsb_pkg
module kqsb_dp #(
	parameter int SLOTS      = kqsb_pkg::DEF_SLOTS,
	parameter int NUM_QUEUES = kqsb_pkg::DEF_NUM_QUEUES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kqsb_pkg::kqsb_cmd_t                cmd,
	input  logic                               req_type,
	input  logic [kqsb_pkg::QNUM_W-1:0]        queue_num,
	input  logic signed [kqsb_pkg::DATA_W-1:0] data_in,
	input  logic                               cfg_we,
	input  logic [kqsb_pkg::ACT_W-1:0]         cfg_wdata,
	output logic [1:0]                         status,
	output logic signed [kqsb_pkg::DATA_W-1:0] data_out
);
	import kqsb_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	// memories
	logic [LW-1:0]            link_mem [SLOTS];
	logic signed [DATA_W-1:0] data_mem [SLOTS];

	// pointer state
	logic [LW-1:0] head_q [NUM_QUEUES];
	logic [AW-1:0] tail_q [NUM_QUEUES];
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] wm_q;     // slots at or above this were never taken
	logic [ACT_W-1:0] act_q;

	// captured request and memory read data
	logic                     req_type_q;
	logic [QNUM_W-1:0]        qnum_q;
	logic signed [DATA_W-1:0] data_in_q;
	logic [LW-1:0]            link_rd_q;
	logic signed [DATA_W-1:0] data_rd_q;

	// result register
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] data_out_q;

	// read address at capture
	logic [QW-1:0] in_qidx;
	logic [AW-1:0] rd_addr;
	assign in_qidx = QW'(queue_num);
	assign rd_addr = (req_type == REQ_DEQ) ? AW'(head_q[in_qidx]) : AW'(free_head_q);

	// capture request and read both memories
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			qnum_q     <= queue_num;
			data_in_q  <= data_in;
			link_rd_q  <= link_mem[rd_addr];
			data_rd_q  <= data_mem[rd_addr];
		end
	end

	// commit decode
	logic [QW-1:0]            qidx;
	logic                     q_valid;
	logic [LW-1:0]            head;
	logic                     q_empty;
	logic                     link_we;
	logic [AW-1:0]            link_wa;
	logic [LW-1:0]            link_wd;
	logic                     data_we;
	logic                     head_we;
	logic [LW-1:0]            head_d;
	logic                     tail_we;
	logic                     free_we;
	logic [LW-1:0]            free_d;
	logic                     wm_inc;
	kqsb_status_t             status_d;
	logic signed [DATA_W-1:0] data_out_d;

	assign qidx    = QW'(qnum_q);
	assign q_valid = (32'(qnum_q) < NUM_QUEUES) && ({1'b0, qnum_q} < act_q);
	assign head    = head_q[qidx];
	assign q_empty = (head == NIL);

	always_comb begin
		link_we    = 1'b0;
		link_wa    = tail_q[qidx];
		link_wd    = free_head_q;
		data_we    = 1'b0;
		head_we    = 1'b0;
		head_d     = free_head_q;
		tail_we    = 1'b0;
		free_we    = 1'b0;
		free_d     = link_rd_q;
		wm_inc     = 1'b0;
		status_d   = STAT_OK;
		data_out_d = '0;
		if (!q_valid) begin
			status_d = STAT_INVALID;
		end else if (req_type_q == REQ_ENQ) begin
			if (free_head_q == NIL) begin
				status_d = STAT_FULL;
			end else begin
				// take the free head; an untouched slot links to the next one up
				data_we = 1'b1;
				tail_we = 1'b1;
				free_we = 1'b1;
				if (free_head_q == wm_q) begin
					wm_inc = 1'b1;
					free_d = wm_q + 1'b1;
				end
				if (q_empty) begin
					head_we = 1'b1;
				end else begin
					link_we = 1'b1;
					link_wa = tail_q[qidx];
					link_wd = free_head_q;
				end
			end
		end else begin
			if (q_empty) begin
				status_d = STAT_EMPTY;
			end else begin
				// unlink head, the queue empties when head meets tail
				head_we    = 1'b1;
				head_d     = (AW'(head) == tail_q[qidx]) ? NIL : link_rd_q;
				link_we    = 1'b1;
				link_wa    = AW'(head);
				link_wd    = free_head_q;
				free_we    = 1'b1;
				free_d     = head;
				data_out_d = data_rd_q;
			end
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.commit && link_we) link_mem[link_wa] <= link_wd;
		if (cmd.commit && data_we) data_mem[AW'(free_head_q)] <= data_in_q;
	end

	// tails and result word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (tail_we) tail_q[qidx] <= AW'(free_head_q);
			status_q   <= status_d;
			data_out_q <= data_out_d;
		end
	end

	// pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) head_q[i] <= NIL;
			free_head_q <= '0;
			wm_q        <= '0;
		end else if (cmd.commit) begin
			if (head_we) head_q[qidx] <= head_d;
			if (free_we) free_head_q <= free_d;
			if (wm_inc) wm_q <= wm_q + 1'b1;
		end
	end

	// queue count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_RESET;
		end else if (cfg_we) begin
			act_q <= cfg_wdata;
		end
	end

	assign status   = status_q;
	assign data_out = data_out_q;

endmodule

@@ sv/k_queues_shared_buffer.sv @@
// channel  | dir | payload                        | handshake
// req      | in  | req_type, queue_num, data_in   | valid / ready
// rsp      | out | status, data_out               | valid / ready
// cfg      | in  | cfg_wdata (active_queues)      | cfg_we, no wait
//
// one request at a time: the accept edge reads the link and data memories,
// then the commit in ST_EXEC writes links and pointers and loads the result word.
// a result still waiting on rsp holds the commit cycle; no new request is taken
// until that commit is done.
// reset needs no clearing pass: never-used slots are tracked by a
// watermark and link to the slot above them.
// top level: controller plus datapath; depends on kqsb_pkg, kqsb_if, kqsb_ctrl, kqsb_dp and the defines header
`include "k_queues_shared_buffer_defines.svh"
module k_queues_shared_buffer #(
	parameter int SLOTS      = kqsb_pkg::DEF_SLOTS,
	parameter int NUM_QUEUES = kqsb_pkg::DEF_NUM_QUEUES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	kqsb_req_if.sink                   req,
	kqsb_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [kqsb_pkg::ACT_W-1:0] cfg_wdata
);
	import kqsb_pkg::*;

	kqsb_cmd_t cmd;

	// sequencer
	kqsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// store and pointers
	kqsb_dp #(
		.SLOTS      (SLOTS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (req.req_type),
		.queue_num (req.queue_num),
		.data_in   (req.data_in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (rsp.status),
		.data_out  (rsp.data_out)
	);

	// checks
	`KQSB_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	`KQSB_ASSERT_NXT(a_commit_shows_word, cmd.commit, rsp.valid)
	`KQSB_ASSERT_IMP(a_no_commit_in_accept, cmd.capture, !cmd.commit)
	`KQSB_ASSERT_IMP(a_zero_on_error, rsp.valid && (rsp.status != STAT_OK), rsp.data_out == '0)

endmodule
